// File: hdl/kprt_pkg.sv
package kprt_pkg;

  localparam int CNT_W  = 5;
  localparam int TIME_W = 32;
  localparam int TAG_W  = 64;

  localparam logic [TIME_W-1:0] NO_SAMPLE = '1;
  localparam logic [CNT_W-1:0]  LIMIT_RST = 5'd4;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_PONG = 1'b1;

  // microprogram step addresses
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEND,
    ST_WRITE,
    ST_SCAN,
    ST_CMP,
    ST_SAMPLE,
    ST_RESULT
  } step_t;

  // jump conditions, taken when true, else fall through to the next step
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_START,
    C_PONG,
    C_FULL,
    C_SCAN_END,
    C_MISS
  } cond_t;

  // datapath controls, one bit per action
  typedef struct packed {
    logic ld_in;
    logic wr_q;
    logic adv;
    logic ld_delay;
    logic deq;
    logic upd_stats;
    logic set_ok;
    logic result;
  } ctl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic start;
    logic pong;
    logic full;
    logic scan_end;
    logic hit;
  } sts_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    ctl_t  ctl;
  } uword_t;

  localparam ctl_t CTL_NONE = '0;

  // the control store
  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    w = '{cond: C_ALWAYS, target: ST_IDLE, ctl: CTL_NONE};
    unique case (pc)
      ST_IDLE: begin
        w.cond = C_NO_START;
        w.target = ST_IDLE;
        w.ctl.ld_in = 1'b1;
      end
      ST_DISPATCH: begin
        w.cond = C_PONG;
        w.target = ST_SCAN;
      end
      ST_SEND: begin
        w.cond = C_FULL;
        w.target = ST_RESULT;
      end
      ST_WRITE: begin
        w.cond = C_ALWAYS;
        w.target = ST_RESULT;
        w.ctl.wr_q = 1'b1;
        w.ctl.set_ok = 1'b1;
      end
      ST_SCAN: begin
        w.cond = C_SCAN_END;
        w.target = ST_RESULT;
      end
      ST_CMP: begin
        w.cond = C_MISS;
        w.target = ST_SCAN;
        w.ctl.adv = 1'b1;
        w.ctl.ld_delay = 1'b1;
      end
      ST_SAMPLE: begin
        w.cond = C_ALWAYS;
        w.target = ST_RESULT;
        w.ctl.deq = 1'b1;
        w.ctl.upd_stats = 1'b1;
        w.ctl.set_ok = 1'b1;
      end
      ST_RESULT: begin
        w.cond = C_ALWAYS;
        w.target = ST_IDLE;
        w.ctl.result = 1'b1;
      end
      default: w = '{cond: C_ALWAYS, target: ST_IDLE, ctl: CTL_NONE};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/kprt_seq.sv
module kprt_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  kprt_pkg::sts_t sts,
  output kprt_pkg::ctl_t ctl,
  output logic           busy
);

  kprt_pkg::step_t  pc_r;
  kprt_pkg::step_t  pc_nxt;
  kprt_pkg::uword_t uw;
  logic             take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= kprt_pkg::ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    uw = kprt_pkg::ucode(pc_r);
    unique case (uw.cond)
      kprt_pkg::C_ALWAYS:   take = 1'b1;
      kprt_pkg::C_NO_START: take = !sts.start;
      kprt_pkg::C_PONG:     take = sts.pong;
      kprt_pkg::C_FULL:     take = sts.full;
      kprt_pkg::C_SCAN_END: take = sts.scan_end;
      kprt_pkg::C_MISS:     take = !sts.hit;
      default:              take = 1'b1;
    endcase
    pc_nxt = take ? uw.target : kprt_pkg::step_t'(pc_r + 3'd1);
    ctl    = uw.ctl;
    busy   = (pc_r != kprt_pkg::ST_IDLE);
  end

endmodule

// File: hdl/kprt_queue.sv
module kprt_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kprt_pkg::ctl_t               ctl,
  input  logic [kprt_pkg::CNT_W-1:0]   limit,
  input  logic                         op,
  input  logic [TAG_BITS-1:0]          tag,
  input  logic [kprt_pkg::TIME_W-1:0]  now_ms,
  output logic                         pong,
  output logic                         full,
  output logic                         scan_end,
  output logic                         hit,
  output logic [kprt_pkg::TIME_W-1:0]  delay,
  output logic [kprt_pkg::CNT_W-1:0]   count
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SUM_W = ((IDX_W > kprt_pkg::CNT_W) ? IDX_W : kprt_pkg::CNT_W) + 1;

  logic [TAG_BITS-1:0]         mem_tag [QUEUE_DEPTH];
  logic [kprt_pkg::TIME_W-1:0] mem_time [QUEUE_DEPTH];

  logic [TAG_BITS-1:0]         rd_tag_r;
  logic [kprt_pkg::TIME_W-1:0] rd_time_r;

  logic                        op_r;
  logic [TAG_BITS-1:0]         tag_r;
  logic [kprt_pkg::TIME_W-1:0] now_r;
  logic [kprt_pkg::TIME_W-1:0] delay_r;

  logic [IDX_W-1:0]            oldest_r;
  logic [kprt_pkg::CNT_W-1:0]  count_r;
  logic [kprt_pkg::CNT_W-1:0]  idx_r;
  logic [IDX_W-1:0]            slot_r;

  logic [SUM_W-1:0]            wr_sum;
  logic [IDX_W-1:0]            wr_slot;
  logic [IDX_W-1:0]            slot_inc;

  // tail slot, count is below depth whenever a write happens
  always_comb begin
    wr_sum = SUM_W'(oldest_r) + SUM_W'(count_r);
    if (wr_sum >= SUM_W'(QUEUE_DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(QUEUE_DEPTH);
    end
    wr_slot = wr_sum[IDX_W-1:0];
    slot_inc = (slot_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : slot_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_q) begin
      mem_tag[wr_slot]  <= tag_r;
      mem_time[wr_slot] <= now_r;
    end
    rd_tag_r  <= mem_tag[slot_r];
    rd_time_r <= mem_time[slot_r];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      op_r  <= op;
      tag_r <= tag;
      now_r <= now_ms;
    end
    if (ctl.ld_delay) begin
      delay_r <= now_r - rd_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      idx_r    <= '0;
      slot_r   <= '0;
    end else begin
      if (ctl.ld_in) begin
        idx_r  <= '0;
        slot_r <= oldest_r;
      end else if (ctl.adv) begin
        idx_r  <= idx_r + 1'b1;
        slot_r <= slot_inc;
      end
      // scan pointer already sits past the match
      if (ctl.deq) begin
        oldest_r <= slot_r;
        count_r  <= count_r - idx_r;
      end else if (ctl.wr_q) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign pong     = (op_r == kprt_pkg::OP_PONG);
  assign full     = (count_r >= limit) ||
                    (SUM_W'(count_r) >= SUM_W'(QUEUE_DEPTH));
  assign scan_end = (idx_r == count_r);
  assign hit      = (rd_tag_r == tag_r);
  assign delay    = delay_r;
  assign count    = count_r;

endmodule

// File: hdl/kprt_stats.sv
module kprt_stats (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  logic [kprt_pkg::TIME_W-1:0] delay,
  output logic [kprt_pkg::TIME_W-1:0] last_rtt,
  output logic [kprt_pkg::TIME_W-1:0] avg_rtt,
  output logic [kprt_pkg::TIME_W-1:0] min_rtt,
  output logic [kprt_pkg::TIME_W-1:0] max_rtt
);

  logic [kprt_pkg::TIME_W-1:0] last_r;
  logic [kprt_pkg::TIME_W-1:0] avg_r;
  logic [kprt_pkg::TIME_W-1:0] min_r;
  logic [kprt_pkg::TIME_W-1:0] max_r;
  logic [kprt_pkg::TIME_W-1:0] avg_base;
  logic [kprt_pkg::TIME_W-1:0] avg_nxt;
  logic                        below_min;

  always_comb begin
    below_min = (delay < min_r);
    // first sample seeds the average
    avg_base  = (below_min && (min_r == kprt_pkg::NO_SAMPLE)) ? delay : avg_r;
    avg_nxt   = avg_base + (delay >> 2) - (avg_base >> 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      avg_r  <= '0;
      min_r  <= kprt_pkg::NO_SAMPLE;
      max_r  <= '0;
    end else if (upd) begin
      last_r <= delay;
      avg_r  <= avg_nxt;
      if (below_min) begin
        min_r <= delay;
      end
      if (delay > max_r) begin
        max_r <= delay;
      end
    end
  end

  assign last_rtt = last_r;
  assign avg_rtt  = avg_r;
  assign min_rtt  = min_r;
  assign max_rtt  = max_r;

endmodule

// File: hdl/keepalive_ping_rtt_tracker.sv
// channel   ports                                            transfer when
// ------    ----------------------------------------------   -----------------------
// input     start, busy, in_operation, in_tag, in_now_ms     start high, busy low
// result    out_valid, out_accepted, out_*_rtt, out_pending  out_valid high, 1 cycle
// config    cfg_valid, cfg_ready, cfg_data                   cfg_valid and cfg_ready
//
// a send runs the dispatch, send and write steps, then the result (a refused send
// skips write); a pong alternates scan and compare steps per entry, hit or miss;
// the queue memory is read once per compared entry, which sets the scan pace
// one item at a time: busy stays high until the result strobe has gone out
// synchronous active-low reset empties the queue and restores the statistics,
// the limit returns to 4; the result side cannot stall
module keepalive_ping_rtt_tracker #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              start,
  output logic                              busy,
  input  logic                              in_operation,
  input  logic [kprt_pkg::TAG_W-1:0]        in_tag,
  input  logic [kprt_pkg::TIME_W-1:0]       in_now_ms,

  output logic                              out_valid,
  output logic                              out_accepted,
  output logic [kprt_pkg::TIME_W-1:0]       out_last_rtt,
  output logic [kprt_pkg::TIME_W-1:0]       out_avg_rtt,
  output logic [kprt_pkg::TIME_W-1:0]       out_min_rtt,
  output logic [kprt_pkg::TIME_W-1:0]       out_max_rtt,
  output logic [kprt_pkg::CNT_W-1:0]        out_pending,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kprt_pkg::CNT_W-1:0]        cfg_data
);

  kprt_pkg::ctl_t              ctl;
  kprt_pkg::sts_t              sts;
  logic [kprt_pkg::CNT_W-1:0]  limit_r;
  logic                        ok_r;
  logic [kprt_pkg::TIME_W-1:0] delay;

  // limit register, written only while the block is idle
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= kprt_pkg::LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  assign sts.start = start;

  // microprogram sequencer
  kprt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // pending queue, scan pointer and delay measurement
  kprt_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .limit    (limit_r),
    .op       (in_operation),
    .tag      (in_tag[TAG_BITS-1:0]),
    .now_ms   (in_now_ms),
    .pong     (sts.pong),
    .full     (sts.full),
    .scan_end (sts.scan_end),
    .hit      (sts.hit),
    .delay    (delay),
    .count    (out_pending)
  );

  // round-trip statistics
  kprt_stats u_stats (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (ctl.upd_stats),
    .delay    (delay),
    .last_rtt (out_last_rtt),
    .avg_rtt  (out_avg_rtt),
    .min_rtt  (out_min_rtt),
    .max_rtt  (out_max_rtt)
  );

  // accepted flag: cleared on each new item, set by a queued send or a hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else if (ctl.ld_in) begin
      ok_r <= 1'b0;
    end else if (ctl.set_ok) begin
      ok_r <= 1'b1;
    end
  end

  assign out_valid    = ctl.result;
  assign out_accepted = ok_r;

  // result strobe ends the item and frees the input side
  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy after result strobe");

  // an input transfer starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("input transfer did not start work");

  // queue count is within its depth whenever a result goes out
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_pending) <= 32'(QUEUE_DEPTH)))
    else $error("pending count beyond queue depth");

  // once a sample is in, the minimum stays at or below the maximum
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_min_rtt != kprt_pkg::NO_SAMPLE) |-> (out_min_rtt <= out_max_rtt))
    else $error("minimum delay above maximum");

  // a pending count change only comes with an accepted item
  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> $stable(out_pending))
    else $error("pending count moved on a refused item");

endmodule
